// ===== hw/rtl/sgtr_pkg.sv =====
// Shared types, constants and glyph ROM of the scaled glyph text rasterizer.
`default_nettype none

package sgtr_pkg;

  // Request codes
  localparam logic [1:0] REQ_DRAW  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam int CELL_PITCH = 6;  // cell pitch in glyph columns, times scale
  localparam int GLYPH_COLS = 5;
  localparam int PX_W       = 14; // signed pixel column, holds origin plus cell offsets
  localparam int ROW_W      = 11; // signed pixel row arithmetic

  typedef enum logic [2:0] {
    ST_INIT,   // sweep after reset
    ST_IDLE,
    ST_DRAW,
    ST_CLEAR,  // sweep on a clear request
    ST_READ,
    ST_DONE
  } state_t;

  // Five glyph columns, column 0 first; bit r of a column is row r.
  typedef logic [0:GLYPH_COLS-1][7:0] glyph_t;

  localparam glyph_t GLYPH_DIGIT [10] = '{
    '{8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e}, '{8'h00, 8'h42, 8'h7f, 8'h40, 8'h00},
    '{8'h62, 8'h51, 8'h49, 8'h49, 8'h46}, '{8'h22, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h18, 8'h14, 8'h12, 8'h7f, 8'h10}, '{8'h2f, 8'h49, 8'h49, 8'h49, 8'h31},
    '{8'h3e, 8'h49, 8'h49, 8'h49, 8'h32}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h26, 8'h49, 8'h49, 8'h49, 8'h3e}
  };

  localparam glyph_t GLYPH_UPPER [26] = '{
    '{8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e}, '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c},
    '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a}, '{8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f},
    '{8'h00, 8'h41, 8'h7f, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3f, 8'h01},
    '{8'h7f, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7f, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f}, '{8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f},
    '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e}, '{8'h7f, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7f, 8'h01, 8'h01},
    '{8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f}, '{8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f},
    '{8'h7f, 8'h20, 8'h18, 8'h20, 8'h7f}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };

  localparam glyph_t GLYPH_LOWER [26] = '{
    '{8'h20, 8'h54, 8'h54, 8'h54, 8'h78}, '{8'h7f, 8'h48, 8'h44, 8'h44, 8'h38},
    '{8'h38, 8'h44, 8'h44, 8'h44, 8'h20}, '{8'h38, 8'h44, 8'h44, 8'h48, 8'h7f},
    '{8'h38, 8'h54, 8'h54, 8'h54, 8'h18}, '{8'h08, 8'h7e, 8'h09, 8'h01, 8'h02},
    '{8'h18, 8'ha4, 8'ha4, 8'ha4, 8'h78}, '{8'h7f, 8'h08, 8'h04, 8'h04, 8'h78},
    '{8'h00, 8'h44, 8'h7d, 8'h40, 8'h00}, '{8'h20, 8'h40, 8'h44, 8'h3d, 8'h00},
    '{8'h7f, 8'h10, 8'h28, 8'h44, 8'h00}, '{8'h00, 8'h41, 8'h7f, 8'h40, 8'h00},
    '{8'h7c, 8'h04, 8'h18, 8'h04, 8'h78}, '{8'h7c, 8'h08, 8'h04, 8'h04, 8'h78},
    '{8'h38, 8'h44, 8'h44, 8'h44, 8'h38}, '{8'h7c, 8'h14, 8'h14, 8'h14, 8'h08},
    '{8'h08, 8'h14, 8'h14, 8'h18, 8'h7c}, '{8'h7c, 8'h08, 8'h04, 8'h04, 8'h08},
    '{8'h48, 8'h54, 8'h54, 8'h54, 8'h20}, '{8'h04, 8'h3f, 8'h44, 8'h40, 8'h20},
    '{8'h3c, 8'h40, 8'h40, 8'h20, 8'h7c}, '{8'h1c, 8'h20, 8'h40, 8'h20, 8'h1c},
    '{8'h3c, 8'h40, 8'h30, 8'h40, 8'h3c}, '{8'h44, 8'h28, 8'h10, 8'h28, 8'h44},
    '{8'h0c, 8'h50, 8'h50, 8'h50, 8'h3c}, '{8'h44, 8'h64, 8'h54, 8'h4c, 8'h44}
  };

  localparam glyph_t GLYPH_SPACE   = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam glyph_t GLYPH_DASH    = '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
  localparam glyph_t GLYPH_COLON   = '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
  localparam glyph_t GLYPH_PERIOD  = '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
  localparam glyph_t GLYPH_SLASH   = '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
  localparam glyph_t GLYPH_PERCENT = '{8'h63, 8'h13, 8'h08, 8'h64, 8'h63};
  localparam glyph_t GLYPH_PLUS    = '{8'h08, 8'h08, 8'h3e, 8'h08, 8'h08};
  localparam glyph_t GLYPH_QMARK   = '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06};

  // Map a character code to its glyph; unknown codes get the question mark.
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t g;
    if (code inside {["a":"z"]}) begin
      g = GLYPH_LOWER[5'(code - 8'("a"))];
    end else if (code inside {["0":"9"]}) begin
      g = GLYPH_DIGIT[4'(code - 8'("0"))];
    end else if (code inside {["A":"Z"]}) begin
      g = GLYPH_UPPER[5'(code - 8'("A"))];
    end else begin
      case (code)
        8'(" "): g = GLYPH_SPACE;
        8'("-"): g = GLYPH_DASH;
        8'(":"): g = GLYPH_COLON;
        8'("."): g = GLYPH_PERIOD;
        8'("/"): g = GLYPH_SLASH;
        8'("%"): g = GLYPH_PERCENT;
        8'("+"): g = GLYPH_PLUS;
        default: g = GLYPH_QMARK;
      endcase
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sgtr_if.sv =====
// Request and response channel interfaces of the scaled glyph text rasterizer.
`default_nettype none

interface sgtr_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [7:0]        char_code;
  logic [5:0]        char_pos;
  logic signed [11:0] text_x;
  logic signed [6:0] text_y;
  logic [2:0]        glyph_scale;
  logic [8:0]        read_index;

  modport source (
    output valid, req_type, char_code, char_pos, text_x, text_y, glyph_scale, read_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_code, char_pos, text_x, text_y, glyph_scale, read_index,
    output ready
  );
endinterface

interface sgtr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scaled_glyph_text_rasterizer_top.sv =====
// Top level of the scaled glyph text rasterizer: framebuffer memory and draw sequencer.
// Usage
//   req (sink): one beat per request. req_type selects draw one character, clear
//   the framebuffer or read one framebuffer byte. rsp (source): exactly one beat
//   per request, read_data holding the byte for a read and zero otherwise.
//   The framebuffer is one memory of SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) bytes
//   with a single registered read port and a single write port.
// Sequencing
//   One request is worked on at a time; req.ready rises as the response is
//   loaded, so no new request is taken while one is still in progress.
//   Read: the byte passes rd_q and the result register. Spare code, zero scale or
//   glyph wholly off the rows: straight to completion. Draw: 5*s column steps
//   (s = saturated scale), each doing nothing off screen or one read-modify-write
//   per page touched (up to s+1 pages, clipped); the memory port takes one per cycle.
//   Clear: one byte per cycle, SCREEN_WIDTH * pages bytes (512 by default).
// Reset
//   rst starts the same clearing sweep; no request is accepted until it ends.
//   No response is produced for it.
// Stalls
//   The response register holds a finished beat while rsp.ready is low; the next
//   request is still accepted and worked on, and its result waits for the slot.
`default_nettype none

module scaled_glyph_text_rasterizer_top #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32,
  parameter int MAX_SCALE     = 4
) (
  input  wire         clk,
  input  wire         rst,
  sgtr_req_if.sink    req,
  sgtr_rsp_if.source  rsp
);

  localparam int PAGES    = (SCREEN_HEIGHT + 7) / 8;
  localparam int FB_BYTES = SCREEN_WIDTH * PAGES;
  localparam int AW       = $clog2(FB_BYTES);
  localparam int PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int SW       = $clog2(MAX_SCALE + 1);
  localparam int EW       = 8 * MAX_SCALE;   // rows of one expanded glyph column
  localparam int EIW      = $clog2(EW);
  localparam int PX_W     = sgtr_pkg::PX_W;
  localparam int ROW_W    = sgtr_pkg::ROW_W;

  // ---------------------------------------------------------------- state
  sgtr_pkg::state_t state, state_next;

  logic [AW-1:0]           clr_addr;
  sgtr_pkg::glyph_t        glyph;
  logic [SW-1:0]           scale;
  logic [SW-1:0]           dx;
  logic [2:0]              col;
  logic signed [PX_W-1:0]  px;
  logic signed [6:0]       ty;
  logic [PW-1:0]           pg;
  logic [PW-1:0]           page_lo;
  logic [PW-1:0]           page_hi;
  logic                    rd_ok;
  logic [7:0]              res_data;

  // read-modify-write stage: the read issued last cycle comes back in rd_q
  logic                    wr_pend;
  logic [AW-1:0]           wr_addr;
  logic [7:0]              wr_mask;

  // framebuffer memory
  logic [7:0]              mem [FB_BYTES];
  logic [7:0]              rd_q;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [7:0]              mem_wdata;

  // ---------------------------------------------------------------- request decode
  logic                    acc;
  logic [SW-1:0]           scale_c;
  logic [PX_W-1:0]         cell_off_c;
  logic signed [PX_W-1:0]  origin_c;
  logic signed [ROW_W-1:0] ty_c;
  logic signed [ROW_W-1:0] bot_c;
  logic signed [ROW_W-1:0] lo_c;
  logic signed [ROW_W-1:0] hi_c;
  logic                    empty_c;

  always_comb begin
    acc        = req.valid && req.ready;
    // saturate the scale
    scale_c    = (32'(req.glyph_scale) > MAX_SCALE) ? SW'(MAX_SCALE) : SW'(req.glyph_scale);
    cell_off_c = PX_W'(req.char_pos) * (PX_W'(scale_c) * PX_W'(sgtr_pkg::CELL_PITCH));
    origin_c   = $signed({{(PX_W-12){req.text_x[11]}}, req.text_x}) + $signed(cell_off_c);
    ty_c       = $signed({{(ROW_W-7){req.text_y[6]}}, req.text_y});
    bot_c      = ty_c + $signed(ROW_W'(scale_c) << 3) - $signed(ROW_W'(1));
    lo_c       = (ty_c < 0) ? '0 : (ty_c >>> 3);
    hi_c       = (bot_c >>> 3);
    // nothing to touch: zero scale, or the glyph lies wholly above or below the screen
    empty_c    = (scale_c == '0) || (bot_c < 0) || (lo_c >= PAGES);
  end

  // ---------------------------------------------------------------- draw datapath
  logic [7:0]              gbyte;
  logic [EW-1:0]           exp_tab [MAX_SCALE+1];
  logic [EW-1:0]           exp_col;
  logic [ROW_W-1:0]        row0;
  logic signed [ROW_W-1:0] rel0;
  logic [7:0]              mask;
  logic                    col_on;
  logic [AW-1:0]           draw_addr;
  logic                    col_last;
  logic                    dx_last;
  logic                    draw_last;

  // Expand the glyph column vertically for every scale: row r fills s rows.
  always_comb begin
    gbyte = glyph[col];
    for (int s = 0; s <= MAX_SCALE; s++) begin
      exp_tab[s] = '0;
      for (int r = 0; r < 8; r++) begin
        for (int d = 0; d < s; d++) begin
          exp_tab[s][r*s + d] = gbyte[r];
        end
      end
    end
    exp_col = exp_tab[scale];
  end

  // Pick the eight rows of page pg out of the expanded column, clipped at the bottom.
  always_comb begin
    logic signed [ROW_W-1:0] idx;
    logic [ROW_W-1:0]        row;
    row0 = ROW_W'(pg) << 3;
    rel0 = $signed(row0) - $signed({{(ROW_W-7){ty[6]}}, ty});
    for (int b = 0; b < 8; b++) begin
      idx = rel0 + $signed(ROW_W'(b));
      row = row0 + ROW_W'(b);
      mask[b] = (idx >= 0) && (idx < EW) && (32'(row) < SCREEN_HEIGHT) &&
                exp_col[idx[EIW-1:0]];
    end
  end

  always_comb begin
    col_on    = (px >= 0) && (px < SCREEN_WIDTH);
    draw_addr = AW'(px) + AW'(pg) * AW'(SCREEN_WIDTH);
    col_last  = !col_on || (pg == page_hi);
    dx_last   = (dx == scale - SW'(1));
    draw_last = col_last && dx_last && (col == 3'(sgtr_pkg::GLYPH_COLS - 1));
  end

  // ---------------------------------------------------------------- control
  logic clr_we;
  logic clr_end;
  logic issue;
  logic out_load;

  always_comb begin
    clr_end    = (clr_addr == AW'(FB_BYTES - 1));
    state_next = state;
    case (state)
      sgtr_pkg::ST_INIT: begin
        if (clr_end) state_next = sgtr_pkg::ST_IDLE;
      end
      sgtr_pkg::ST_CLEAR: begin
        if (clr_end) state_next = sgtr_pkg::ST_DONE;
      end
      sgtr_pkg::ST_IDLE: begin
        if (acc) begin
          case (req.req_type)
            sgtr_pkg::REQ_DRAW:  state_next = empty_c ? sgtr_pkg::ST_DONE : sgtr_pkg::ST_DRAW;
            sgtr_pkg::REQ_CLEAR: state_next = sgtr_pkg::ST_CLEAR;
            sgtr_pkg::REQ_READ:  state_next = sgtr_pkg::ST_READ;
            default:             state_next = sgtr_pkg::ST_DONE;
          endcase
        end
      end
      sgtr_pkg::ST_DRAW: begin
        if (draw_last) state_next = sgtr_pkg::ST_DONE;
      end
      sgtr_pkg::ST_READ: begin
        state_next = sgtr_pkg::ST_DONE;
      end
      sgtr_pkg::ST_DONE: begin
        if (!rsp.valid || rsp.ready) state_next = sgtr_pkg::ST_IDLE;
      end
      default: state_next = sgtr_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    req.ready = (state == sgtr_pkg::ST_IDLE);
    clr_we    = (state == sgtr_pkg::ST_INIT) || (state == sgtr_pkg::ST_CLEAR);
    issue     = (state == sgtr_pkg::ST_DRAW) && col_on;
    out_load  = (state == sgtr_pkg::ST_DONE) && (!rsp.valid || rsp.ready);
    rd_addr   = (state == sgtr_pkg::ST_DRAW) ? draw_addr : AW'(req.read_index);
    mem_we    = clr_we || wr_pend;
    mem_waddr = clr_we ? clr_addr : wr_addr;
    mem_wdata = clr_we ? 8'h00 : (rd_q | wr_mask);
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sgtr_pkg::ST_INIT;
      clr_addr  <= '0;
      wr_pend   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= (clr_we && !clr_end) ? clr_addr + AW'(1) : '0;
      wr_pend   <= issue;
      rsp.valid <= out_load || (rsp.valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      glyph    <= sgtr_pkg::glyph_lookup(req.char_code);
      scale    <= scale_c;
      ty       <= req.text_y;
      px       <= origin_c;
      col      <= '0;
      dx       <= '0;
      pg       <= PW'(lo_c);
      page_lo  <= PW'(lo_c);
      page_hi  <= (hi_c > PAGES - 1) ? PW'(PAGES - 1) : PW'(hi_c);
      rd_ok    <= (32'(req.read_index) < FB_BYTES);
      res_data <= 8'h00;
    end else if (state == sgtr_pkg::ST_DRAW) begin
      if (col_last) begin
        // advance to the next screen column
        pg <= page_lo;
        px <= px + PX_W'(1);
        if (dx_last) begin
          dx  <= '0;
          col <= col + 3'd1;
        end else begin
          dx <= dx + SW'(1);
        end
      end else begin
        pg <= pg + PW'(1);
      end
    end else if (state == sgtr_pkg::ST_READ) begin
      res_data <= rd_ok ? rd_q : 8'h00;
    end
    if (issue) begin
      wr_addr <= draw_addr;
      wr_mask <= mask;
    end
    if (out_load) begin
      rsp.read_data <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  // ---------------------------------------------------------------- checks
  a_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(wr_pend && clr_we))
    else $error("merge write collides with clearing sweep");

  a_wr_from_draw: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> $past(state == sgtr_pkg::ST_DRAW))
    else $error("merge write without a draw issue");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == sgtr_pkg::ST_DONE))
    else $error("response raised outside completion");

  a_page_window: assert property (@(posedge clk) disable iff (rst)
    (state == sgtr_pkg::ST_DRAW) |-> (pg >= page_lo && pg <= page_hi))
    else $error("draw page outside the glyph's page window");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the scaled glyph text rasterizer.
`timescale 1ns / 100ps

module tb_top;

  // Request codes, taken from the package by name.
  localparam logic [1:0] REQ_DRAW  = sgtr_pkg::REQ_DRAW;
  localparam logic [1:0] REQ_CLEAR = sgtr_pkg::REQ_CLEAR;
  localparam logic [1:0] REQ_READ  = sgtr_pkg::REQ_READ;

  // Screen geometry and limits of the default build.
  localparam int SCR_W       = 128;
  localparam int SCR_H       = 32;
  localparam int SCALE_CAP   = 4;
  localparam int FRAME_BYTES = SCR_W * ((SCR_H + 7) / 8);
  localparam int PITCH       = 6;

  // The spare request code: no effect, zero response.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 150;   // longest draw plus response stall, with margin
  localparam int CYCLE_LIMIT  = 4000000;

  // Glyph columns packed column 0 first (bits 39:32); bit r of a column is row r.
  localparam logic [39:0] DIGIT_COLS [10] = '{
    40'h3e5149453e, 40'h00427f4000, 40'h6251494946, 40'h2249494936, 40'h1814127f10,
    40'h2f49494931, 40'h3e49494932, 40'h0171090503, 40'h3649494936, 40'h264949493e
  };
  localparam logic [39:0] UPPER_COLS [26] = '{
    40'h7e1111117e, 40'h7f49494936, 40'h3e41414122, 40'h7f4141221c, 40'h7f49494941,
    40'h7f09090901, 40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100, 40'h2040413f01,
    40'h7f08142241, 40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931, 40'h01017f0101,
    40'h3f4040403f, 40'h1f2040201f, 40'h7f2018207f, 40'h6314081463, 40'h0708700807,
    40'h6151494543
  };
  localparam logic [39:0] LOWER_COLS [26] = '{
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h18a4a4a478, 40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
    40'h4464544c44
  };

  // Characters with a glyph of their own; random draws pick mostly from these.
  localparam string CHARSET =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz -:./%+";

  // One request beat; has_literal marks a directed row whose response is typed in.
  typedef struct {
    logic [1:0]         kind;
    logic [7:0]         code;
    logic [5:0]         pos;
    logic signed [11:0] x;
    logic signed [6:0]  y;
    logic [2:0]         scale;
    logic [8:0]         index;
    bit                 has_literal;
    logic [7:0]         literal_data;
  } raster_req_t;

  logic clk = 1'b0;
  logic rst;

  sgtr_req_if req_ch ();
  sgtr_rsp_if rsp_ch ();

  scaled_glyph_text_rasterizer_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow framebuffer and the bytes the block owes us, oldest first.
  logic [7:0] frame_shadow [FRAME_BYTES];
  logic [7:0] pending_bytes [$];
  int         error_count = 0;
  int         cycle_count = 0;

  // Unknown codes fall through to the question mark.
  function automatic logic [39:0] glyph_columns(input logic [7:0] code);
    if (code >= "a" && code <= "z") return LOWER_COLS[code - "a"];
    if (code >= "0" && code <= "9") return DIGIT_COLS[code - "0"];
    if (code >= "A" && code <= "Z") return UPPER_COLS[code - "A"];
    case (code)
      " ":     return 40'h0000000000;
      "-":     return 40'h0808080808;
      ":":     return 40'h0036360000;
      ".":     return 40'h0060600000;
      "/":     return 40'h2010080402;
      "%":     return 40'h6313086463;
      "+":     return 40'h08083e0808;
      default: return 40'h0201510906;
    endcase
  endfunction

  // Expand every set glyph bit to an s-by-s block, clip to the screen and OR it in.
  function automatic void rasterize_char(input raster_req_t r);
    int          s;
    int          origin;
    int          px;
    int          py;
    logic [39:0] cols;
    logic [7:0]  col_bits;
    s = (r.scale > SCALE_CAP) ? SCALE_CAP : int'(r.scale);
    if (s > 0) begin
      cols   = glyph_columns(r.code);
      origin = int'(r.x) + int'(r.pos) * PITCH * s;
      for (int c = 0; c < 5; c++) begin
        col_bits = cols[39 - 8 * c -: 8];
        for (int row = 0; row < 8; row++) begin
          if (col_bits[row]) begin
            for (int dx = 0; dx < s; dx++) begin
              for (int dy = 0; dy < s; dy++) begin
                px = origin + c * s + dx;
                py = int'(r.y) + row * s + dy;
                if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H)
                  frame_shadow[px + (py / 8) * SCR_W] |= 8'(1 << (py % 8));
              end
            end
          end
        end
      end
    end
  endfunction

  // Apply one accepted request to the shadow and return the byte it answers with.
  function automatic logic [7:0] serve_request(input raster_req_t r);
    logic [7:0] data;
    data = 8'h00;
    case (r.kind)
      REQ_DRAW:  rasterize_char(r);
      REQ_CLEAR: foreach (frame_shadow[i]) frame_shadow[i] = 8'h00;
      REQ_READ:  if (int'(r.index) < FRAME_BYTES) data = frame_shadow[r.index];
      default:   data = 8'h00;
    endcase
    return data;
  endfunction

  function automatic raster_req_t make_req(input logic [1:0] kind, input logic [7:0] code,
                                           input int pos, input int x, input int y,
                                           input int scale, input int index,
                                           input bit has_literal, input logic [7:0] lit);
    raster_req_t r;
    r.kind         = kind;
    r.code         = code;
    r.pos          = 6'(pos);
    r.x            = 12'(x);
    r.y            = 7'(y);
    r.scale        = 3'(scale);
    r.index        = 9'(index);
    r.has_literal  = has_literal;
    r.literal_data = lit;
    return r;
  endfunction

  // Random request: draws that land on or near the screen (the largest share), many reads,
  // the odd clear and spare code, and some draws with wholly random fields.
  function automatic raster_req_t random_request();
    raster_req_t r;
    int          roll;
    int          s;
    int          target;
    int          x;
    r = make_req(REQ_DRAW, 8'($urandom), $urandom_range(0, 63), $urandom_range(0, 4095),
                 $urandom_range(0, 127), $urandom_range(0, 7), $urandom_range(0, 511),
                 1'b0, 8'h00);
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      r.kind = REQ_CLEAR;
    end else if (roll < 5) begin
      r.kind = REQ_SPARE;
    end else if (roll < 40) begin
      r.kind = REQ_READ;
    end else if (roll < 88) begin
      // aim the cell origin at the screen, whatever the string position
      roll = $urandom_range(0, 9);
      if (roll == 0) s = 0;
      else if (roll == 1) s = $urandom_range(5, 7);
      else s = $urandom_range(1, 4);
      r.scale = 3'(s);
      if (s > SCALE_CAP) s = SCALE_CAP;
      if ($urandom_range(0, 9) < 7) r.code = 8'(CHARSET[$urandom_range(0, CHARSET.len() - 1)]);
      if ($urandom_range(0, 1) == 0) r.pos = 6'($urandom_range(0, 7));
      target = $urandom_range(0, 170) - 30;
      x = target - int'(r.pos) * PITCH * s;
      if (x < -2048) x = -2048;
      r.x = 12'(x);
      r.y = 7'($urandom_range(0, 50) - 20);
    end
    return r;
  endfunction

  // Reset once at the start, release on a falling edge.
  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial foreach (frame_shadow[i]) frame_shadow[i] = 8'h00;

  // Response side stalls on a rotating 16-bit pattern, reloaded whenever phase_left runs out:
  // sometimes wide open, sometimes sparse, sometimes dense.
  initial begin : rsp_stall
    logic [15:0] ready_pattern;
    int          phase_left;
    ready_pattern = 16'hffff;
    phase_left    = 0;
    rsp_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        phase_left = 48;
        case ($urandom_range(0, 3))
          0:       ready_pattern = 16'hffff;
          1:       ready_pattern = 16'($urandom) | 16'h0001;
          2:       ready_pattern = 16'($urandom) | 16'($urandom);
          default: ready_pattern = 16'($urandom) & 16'($urandom) | 16'h0101;
        endcase
      end
      phase_left--;
      rsp_ch.ready  <= ready_pattern[0];
      ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // Compare each response beat with the oldest owed byte.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("read_data: unexpected beat, got %02h", rsp_ch.read_data);
        error_count++;
      end else begin
        if (rsp_ch.read_data !== pending_bytes[0]) begin
          $error("read_data mismatch: expected %02h, got %02h",
                 pending_bytes[0], rsp_ch.read_data);
          error_count++;
        end
        void'(pending_bytes.pop_front());
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Request side: directed table first, then random beats, in bursts with gaps.
  initial begin : req_driver
    raster_req_t directed [$];
    raster_req_t r;
    logic [7:0]  answer;
    int          burst_left;
    int          gap_len;
    int          total;

    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_SPARE;
    req_ch.char_code   = '0;
    req_ch.char_pos    = '0;
    req_ch.text_x      = '0;
    req_ch.text_y      = '0;
    req_ch.glyph_scale = '0;
    req_ch.read_index  = '0;

    // Reads right after reset see a blank frame; draws and spare codes answer zero.
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0, 511, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_SPARE, 8'h00,  0,     0,   0, 0,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_DRAW,  "A",    0,     0,   0, 1,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0,   0, 1'b1, 8'h7e));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0,   1, 1'b0, 8'h00));
    // far left string end and far right origin: everything clipped
    directed.push_back(make_req(REQ_DRAW,  "0",   63, -2048, -64, 4,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_DRAW,  8'hff,  0,  2047,  63, 7,   0, 1'b1, 8'h00));
    // code zero is unsupported; scale 7 saturates; clipped on the right and top
    directed.push_back(make_req(REQ_DRAW,  8'h00,  1,   100,  -3, 7,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0, 124, 1'b0, 8'h00));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0, 127, 1'b0, 8'h00));
    // clipped at the bottom, spans pages 2 and 3
    directed.push_back(make_req(REQ_DRAW,  "%",    2,    10,  20, 3,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0, 302, 1'b0, 8'h00));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0, 432, 1'b0, 8'h00));
    // descender uses row 7 of the glyph
    directed.push_back(make_req(REQ_DRAW,  "g",    0,    60,   5, 2,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0, 190, 1'b0, 8'h00));
    // zero scale leaves the frame alone
    directed.push_back(make_req(REQ_DRAW,  "z",    5,     0,   0, 0,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0,   0, 1'b1, 8'h7e));
    directed.push_back(make_req(REQ_CLEAR, 8'h00,  0,     0,   0, 0,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0, 302, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_DRAW,  " ",    0,     0,   0, 4,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_DRAW,  "/",    0,   120,  24, 2,   0, 1'b1, 8'h00));
    directed.push_back(make_req(REQ_READ,  8'h00,  0,     0,   0, 0, 504, 1'b0, 8'h00));
    directed.push_back(make_req(REQ_SPARE, 8'hff, 63,    -1,  -1, 7, 511, 1'b1, 8'h00));

    // hold off until reset is released; the clearing sweep holds ready low anyway
    @(negedge clk);
    while (rst) @(negedge clk);

    burst_left = $urandom_range(1, 24);
    total      = directed.size() + RANDOM_ITEMS;
    for (int n = 0; n < total; n++) begin
      if (n < directed.size()) r = directed[n];
      else r = random_request();

      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= r.kind;
      req_ch.char_code   <= r.code;
      req_ch.char_pos    <= r.pos;
      req_ch.text_x      <= r.x;
      req_ch.text_y      <= r.y;
      req_ch.glyph_scale <= r.scale;
      req_ch.read_index  <= r.index;

      // advance on the edge that takes the beat
      @(posedge clk);
      while (!req_ch.ready) @(posedge clk);
      answer = serve_request(r);
      if (r.has_literal) pending_bytes.push_back(r.literal_data);
      else pending_bytes.push_back(answer);

      // end of a burst: usually drop valid for a random gap, then start the next burst
      burst_left--;
      gap_len = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) gap_len = $urandom_range(1, 12);
      end
      @(negedge clk);
      if (gap_len > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap_len) @(negedge clk);
      end
    end
    req_ch.valid <= 1'b0;

    // drain owed responses, then give a late stray beat time to show up
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== scaled_glyph_text_rasterizer_top.f =====
hw/rtl/sgtr_pkg.sv
hw/rtl/sgtr_if.sv
hw/rtl/scaled_glyph_text_rasterizer_top.sv
tb/tb_top.sv
